// ===== rtl/lfu_pr_pkg.sv =====
// shared types and constants for the lfu page replacement unit
package lfu_pr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int COUNT_W = 16;
  localparam int AGE_W   = 32;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIU_W      = 5;
  localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

  // register index, taken from paddr above the byte offset
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } lfu_pr_state_t;

  // per-cell update strobes
  typedef struct packed {
    logic age_tick;
    logic bump;
    logic load;
  } lfu_pr_cell_ctrl_t;

endpackage

// ===== rtl/lfu_page_replacement_unit.sv =====
// lfu page replacement unit: top level with control, config register and cell row
// done rises with the result register, once the token has walked the whole cell row
// the unit takes no new request until the previous result is loaded
// the token moves one cell per cycle; busy stays high from accept until the result is loaded
// results are strobed for one cycle on done; the receiver cannot stall them
// rst (synchronous) empties all frames and sets frames_in_use to 16
module lfu_page_replacement_unit #(
  parameter int MAX_FRAMES = lfu_pr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lfu_pr_pkg::PAGE_BITS_DEF,
  localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic [PAGE_BITS-1:0]                page_number,
  // result channel
  output logic                                done,
  output logic                                fault,
  output logic                                evicted_valid,
  output logic [PAGE_BITS-1:0]                evicted_page,
  output logic [IDX_W-1:0]                    frame_slot,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lfu_pr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lfu_pr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lfu_pr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready
);

  lfu_pr_pkg::lfu_pr_state_t state, state_next;

  logic [lfu_pr_pkg::FIU_W-1:0] frames_in_use;
  logic [CNT_W-1:0]             resident_total;
  logic [CNT_W-1:0]             limit;
  logic [IDX_W-1:0]             scan_cnt;
  logic [PAGE_BITS-1:0]         req_page;

  logic accept;
  logic scan_last;
  logic finish;
  logic reg_sel;

  // token chain, entry 0 is the empty token fed to the first cell
  logic                           ch_hit     [0:MAX_FRAMES];
  logic [IDX_W-1:0]               ch_hit_idx [0:MAX_FRAMES];
  logic                           ch_found   [0:MAX_FRAMES];
  logic [lfu_pr_pkg::COUNT_W-1:0] ch_count   [0:MAX_FRAMES];
  logic [lfu_pr_pkg::AGE_W-1:0]   ch_age     [0:MAX_FRAMES];
  logic [IDX_W-1:0]               ch_idx     [0:MAX_FRAMES];
  logic [PAGE_BITS-1:0]           ch_page    [0:MAX_FRAMES];

  lfu_pr_pkg::lfu_pr_cell_ctrl_t cell_ctrl [0:MAX_FRAMES-1];

  // decision made from the tail of the chain
  logic             tail_hit;
  logic             has_room;
  logic [IDX_W-1:0] slot;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[lfu_pr_pkg::CFG_ADDR_W-1] == lfu_pr_pkg::REG_FRAMES_IN_USE;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lfu_pr_pkg::FIU_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frames_in_use <= pwdata[lfu_pr_pkg::FIU_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) prdata = lfu_pr_pkg::CFG_DATA_W'(frames_in_use);
  end

  // effective frame limit: zero acts as one, anything above the row acts as the row
  always_comb begin
    if (frames_in_use == '0) begin
      limit = CNT_W'(1);
    end else if (32'(frames_in_use) > 32'(MAX_FRAMES)) begin
      limit = CNT_W'(MAX_FRAMES);
    end else begin
      limit = CNT_W'(frames_in_use);
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= lfu_pr_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lfu_pr_pkg::ST_IDLE: if (start) state_next = lfu_pr_pkg::ST_SCAN;
      lfu_pr_pkg::ST_SCAN: if (scan_last) state_next = lfu_pr_pkg::ST_DONE;
      lfu_pr_pkg::ST_DONE: state_next = lfu_pr_pkg::ST_IDLE;
      default:             state_next = lfu_pr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    accept = 1'b0;
    finish = 1'b0;
    unique case (state)
      lfu_pr_pkg::ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      lfu_pr_pkg::ST_SCAN: ;
      lfu_pr_pkg::ST_DONE: finish = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

  // the token walks the row one cell per cycle to reach the tail
  assign scan_last = scan_cnt == IDX_W'(MAX_FRAMES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (accept) begin
      scan_cnt <= '0;
    end else if (state == lfu_pr_pkg::ST_SCAN && !scan_last) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_page <= page_number;
  end

  // ---------------- decision at the tail ----------------
  assign tail_hit = ch_hit[MAX_FRAMES];
  assign has_room = resident_total < limit;

  always_comb begin
    if (tail_hit)      slot = ch_hit_idx[MAX_FRAMES];
    else if (has_room) slot = IDX_W'(resident_total);
    else               slot = ch_idx[MAX_FRAMES];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resident_total <= '0;
    end else if (finish && !tail_hit && has_room) begin
      resident_total <= resident_total + 1'b1;
    end
  end

  // per-cell strobes: aging at accept, count bump on hit, load on miss
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      cell_ctrl[i].age_tick = accept;
      cell_ctrl[i].bump     = finish && tail_hit && (slot == IDX_W'(i));
      cell_ctrl[i].load     = finish && !tail_hit && (slot == IDX_W'(i));
    end
  end

  // ---------------- cell row ----------------
  assign ch_hit[0]     = 1'b0;
  assign ch_hit_idx[0] = '0;
  assign ch_found[0]   = 1'b0;
  assign ch_count[0]   = '0;
  assign ch_age[0]     = '0;
  assign ch_idx[0]     = '0;
  assign ch_page[0]    = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lfu_pr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .INDEX     (g)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (cell_ctrl[g]),
      .resident_total (resident_total),
      .req_page       (req_page),
      .in_hit         (ch_hit[g]),
      .in_hit_idx     (ch_hit_idx[g]),
      .in_found       (ch_found[g]),
      .in_count       (ch_count[g]),
      .in_age         (ch_age[g]),
      .in_idx         (ch_idx[g]),
      .in_page        (ch_page[g]),
      .out_hit        (ch_hit[g+1]),
      .out_hit_idx    (ch_hit_idx[g+1]),
      .out_found      (ch_found[g+1]),
      .out_count      (ch_count[g+1]),
      .out_age        (ch_age[g+1]),
      .out_idx        (ch_idx[g+1]),
      .out_page       (ch_page[g+1])
    );
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= finish;
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      fault         <= !tail_hit;
      evicted_valid <= !tail_hit && !has_room;
      evicted_page  <= (!tail_hit && !has_room) ? ch_page[MAX_FRAMES] : '0;
      frame_slot    <= slot;
    end
  end

endmodule

// ===== rtl/lfu_pr_cell.sv =====
// one page frame cell: frame state, hit check and victim compare stage
module lfu_pr_cell #(
  parameter int PAGE_BITS = lfu_pr_pkg::PAGE_BITS_DEF,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5,
  parameter int INDEX     = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lfu_pr_pkg::lfu_pr_cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]              resident_total,
  input  logic [PAGE_BITS-1:0]          req_page,
  // token from the previous cell
  input  logic                          in_hit,
  input  logic [IDX_W-1:0]              in_hit_idx,
  input  logic                          in_found,
  input  logic [lfu_pr_pkg::COUNT_W-1:0] in_count,
  input  logic [lfu_pr_pkg::AGE_W-1:0]  in_age,
  input  logic [IDX_W-1:0]              in_idx,
  input  logic [PAGE_BITS-1:0]          in_page,
  // registered token toward the next cell
  output logic                          out_hit,
  output logic [IDX_W-1:0]              out_hit_idx,
  output logic                          out_found,
  output logic [lfu_pr_pkg::COUNT_W-1:0] out_count,
  output logic [lfu_pr_pkg::AGE_W-1:0]  out_age,
  output logic [IDX_W-1:0]              out_idx,
  output logic [PAGE_BITS-1:0]          out_page
);

  logic [PAGE_BITS-1:0]           page;
  logic [lfu_pr_pkg::COUNT_W-1:0] count;
  logic [lfu_pr_pkg::AGE_W-1:0]   age;
  logic                           resident;
  logic                           match;
  logic                           better;

  assign resident = CNT_W'(INDEX) < resident_total;
  assign match    = resident && (page == req_page);
  assign better   = resident && (!in_found || (count < in_count) ||
                                 ((count == in_count) && (age > in_age)));

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      age   <= '0;
    end else if (ctrl.load) begin
      count <= lfu_pr_pkg::COUNT_W'(1);
      age   <= '0;
    end else if (ctrl.bump) begin
      if (count != '1) count <= count + 1'b1;
    end else if (ctrl.age_tick && resident) begin
      if (age != '1) age <= age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) page <= req_page;
  end

  // token stage: first match wins, strict compare keeps the lower frame on ties
  always_ff @(posedge clk) begin
    if (!in_hit && match) begin
      out_hit     <= 1'b1;
      out_hit_idx <= IDX_W'(INDEX);
    end else begin
      out_hit     <= in_hit;
      out_hit_idx <= in_hit_idx;
    end
    if (better) begin
      out_found <= 1'b1;
      out_count <= count;
      out_age   <= age;
      out_idx   <= IDX_W'(INDEX);
      out_page  <= page;
    end else begin
      out_found <= in_found;
      out_count <= in_count;
      out_age   <= in_age;
      out_idx   <= in_idx;
      out_page  <= in_page;
    end
  end

endmodule
